// ===== hdl/ldcw_pkg.sv =====
package ldcw_pkg;

    localparam int MAX_LEN  = 65536;
    localparam int ALPHABET = 256;

    localparam int CH_W  = 8;
    localparam int POS_W = $clog2(MAX_LEN);
    localparam int LEN_W = POS_W + 1;
    localparam int SYM_W = $clog2(ALPHABET);

    localparam int S_TDATA_W = ((CH_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * LEN_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

endpackage

// ===== hdl/ldcw_ram.sv =====
module ldcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/longest_distinct_char_window.sv =====
// Longest repeat-free window over a byte stream. One byte is taken per clock
// cycle while m_tready does not hold the output, and each byte yields one result:
// the synchronous read of the last-position table is issued at the accepting
// edge along with the stage-1 byte register, and the window update goes into the
// output register once stage 1 may advance. The last position of
// every byte value sits in a 256-entry single-write, single-read memory; the
// entry written by the previous byte is forwarded, so equal bytes in
// consecutive cycles need no stall. The seen flags are flip-flops, so the
// final byte of a string (tlast) resets the table for the next string at once,
// with no clearing pass after reset or between strings. Bytes beyond MAX_LEN
// report a window of 0, the held best length and the too_long flag in tuser.
module longest_distinct_char_window
    import ldcw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // ch
    input  logic                 s_tlast,   // last_char

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // window_len, best_len, zero pad
    output logic                 m_tlast,   // done_res
    output logic [M_TUSER_W-1:0] m_tuser    // too_long
);

    logic             s_fire;
    logic [SYM_W-1:0] s_sym;

    logic             s1_valid_reg, s1_valid_next;
    logic [SYM_W-1:0] s1_sym_reg;
    logic             s1_last_reg;
    logic             s1_go;

    logic [POS_W-1:0] ram_rdata;
    logic             ram_we;

    logic             fwd_valid_reg;
    logic [SYM_W-1:0] fwd_sym_reg;
    logic [POS_W-1:0] fwd_pos_reg;

    logic [ALPHABET-1:0] seen_reg, seen_next;
    logic [POS_W-1:0]    window_start_reg, window_start_next;
    logic [LEN_W-1:0]    position_reg, position_next;
    logic [LEN_W-1:0]    best_reg, best_next;
    logic                overflowed_reg, overflowed_next;

    logic             ovf;
    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] ws_new;
    logic [LEN_W-1:0] win;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [LEN_W-1:0] m_win_reg;
    logic [LEN_W-1:0] m_best_reg;
    logic             m_last_reg;
    logic             m_too_long_reg;

    assign s_sym  = SYM_W'(s_tdata[CH_W-1:0]);
    assign s1_go  = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_fire = s_tvalid && s_tready;

    // table lookup issued in the cycle of acceptance
    ldcw_ram #(
        .WIDTH(POS_W),
        .DEPTH(ALPHABET)
    ) u_last_pos (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (s1_sym_reg),
        .wdata (cur_pos),
        .re    (s_fire),
        .raddr (s_sym),
        .rdata (ram_rdata)
    );

    always_comb begin
        ovf     = position_reg >= LEN_W'(MAX_LEN);
        cur_pos = position_reg[POS_W-1:0];
        // newest write wins over the memory's read data
        if (fwd_valid_reg && (fwd_sym_reg == s1_sym_reg)) begin
            last_pos = fwd_pos_reg;
        end else begin
            last_pos = ram_rdata;
        end
        if (seen_reg[s1_sym_reg] && (last_pos >= window_start_reg)) begin
            ws_new = last_pos + POS_W'(1);
        end else begin
            ws_new = window_start_reg;
        end
        win = ovf ? '0 : ({1'b0, cur_pos} - {1'b0, ws_new} + LEN_W'(1));
        ram_we = s1_go && !ovf;
    end

    always_comb begin
        s1_valid_next     = s_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        seen_next         = seen_reg;
        window_start_next = window_start_reg;
        position_next     = position_reg;
        best_next         = best_reg;
        overflowed_next   = overflowed_reg;
        if (s1_go) begin
            if (ovf) begin
                overflowed_next = 1'b1;
            end else begin
                seen_next[s1_sym_reg] = 1'b1;
                window_start_next     = ws_new;
                position_next         = position_reg + LEN_W'(1);
                if (win > best_reg) begin
                    best_next = win;
                end
            end
            if (s1_last_reg) begin
                seen_next         = '0;
                window_start_next = '0;
                position_next     = '0;
                best_next         = '0;
                overflowed_next   = 1'b0;
            end
        end
        m_tvalid_next = s1_go ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            seen_reg         <= '0;
            window_start_reg <= '0;
            position_reg     <= '0;
            best_reg         <= '0;
            overflowed_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            seen_reg         <= seen_next;
            window_start_reg <= window_start_next;
            position_reg     <= position_next;
            best_reg         <= best_next;
            overflowed_reg   <= overflowed_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (ram_we) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_sym_reg  <= s_sym;
            s1_last_reg <= s_tlast;
        end
        if (ram_we) begin
            fwd_sym_reg <= s1_sym_reg;
            fwd_pos_reg <= cur_pos;
        end
        if (s1_go) begin
            m_win_reg      <= win;
            m_best_reg     <= ((win > best_reg) && !ovf) ? win : best_reg;
            m_last_reg     <= s1_last_reg;
            m_too_long_reg <= overflowed_reg || ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_best_reg, m_win_reg});
    assign m_tlast  = m_last_reg;
    assign m_tuser  = M_TUSER_W'(m_too_long_reg);

`ifndef SYNTHESIS
    a_too_long_zero_win: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[LEN_W-1:0] == '0))
        else $error("window length not zero on an overlong string");

    a_win_le_best: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[LEN_W-1:0] <= m_tdata[2*LEN_W-1:LEN_W]))
        else $error("window length exceeds best length");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && s1_last_reg) |=> ((position_reg == '0) && (seen_reg == '0)
                                    && (best_reg == '0) && !overflowed_reg))
        else $error("string state not cleared after the final byte");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (position_reg <= LEN_W'(MAX_LEN)) && (best_reg <= position_reg))
        else $error("position or best length out of range");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ldcw_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;

    typedef struct packed {
        logic [LEN_W-1:0] window_len;
        logic [LEN_W-1:0] best_len;
        logic             done_res;
        logic             too_long;
    } window_result_t;

    // tracks the repeat-free window per string and queues one expected result per byte
    class window_scoreboard_t;
        int unsigned    last_pos [ALPHABET];
        bit             seen [ALPHABET];
        int unsigned    win_start;
        int unsigned    next_pos;
        int unsigned    best;
        bit             overflowed;
        int             errors;
        window_result_t expected_windows [$];

        function new();
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (seen[i]) begin
                seen[i]     = 1'b0;
                last_pos[i] = 0;
            end
            win_start  = 0;
            next_pos   = 0;
            best       = 0;
            overflowed = 1'b0;
        endfunction

        function int pending();
            return expected_windows.size();
        endfunction

        function void note_char(input logic [CH_W-1:0] ch, input logic last_char);
            int unsigned    sym;
            int unsigned    win;
            window_result_t r;
            sym = ch % ALPHABET;
            win = 0;
            if (next_pos >= MAX_LEN) begin
                overflowed = 1'b1;
            end else begin
                // an earlier copy inside the window pushes the start past it
                if (seen[sym] && last_pos[sym] + 1 > win_start) begin
                    win_start = last_pos[sym] + 1;
                end
                win = next_pos - win_start + 1;
                if (win > best) begin
                    best = win;
                end
                last_pos[sym] = next_pos;
                seen[sym]     = 1'b1;
                next_pos      = next_pos + 1;
            end
            r.window_len = win[LEN_W-1:0];
            r.best_len   = best[LEN_W-1:0];
            r.done_res   = last_char;
            r.too_long   = overflowed;
            expected_windows.push_back(r);
            if (last_char) begin
                clear_string();
            end
        endfunction

        function void check_result(input window_result_t got);
            window_result_t want;
            if (expected_windows.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: window_len=%0d best_len=%0d",
                         $time, got.window_len, got.best_len);
                return;
            end
            want = expected_windows.pop_front();
            if (got.window_len !== want.window_len) begin
                errors++;
                $display("%0t: window_len expected %0d actual %0d",
                         $time, want.window_len, got.window_len);
            end
            if (got.best_len !== want.best_len) begin
                errors++;
                $display("%0t: best_len expected %0d actual %0d",
                         $time, want.best_len, got.best_len);
            end
            if (got.done_res !== want.done_res) begin
                errors++;
                $display("%0t: done_res expected %0b actual %0b",
                         $time, want.done_res, got.done_res);
            end
            if (got.too_long !== want.too_long) begin
                errors++;
                $display("%0t: too_long expected %0b actual %0b",
                         $time, want.too_long, got.too_long);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;

    window_scoreboard_t sb;
    idle_mode_t         tx_mode;
    idle_mode_t         rx_mode;
    int                 hold_cycles;

    longest_distinct_char_window dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic int draw_wait(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    task automatic send_char(input logic [CH_W-1:0] ch, input logic last_char);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last_char;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_char(ch, last_char);
    endtask

    task automatic send_word(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], i == text.len() - 1);
        end
    endtask

    // span picks how many distinct bytes the string draws from; a run walks the alphabet
    task automatic send_random_string(input int len, input int span, input bit run);
        int unsigned base;
        logic [7:0]  ch;
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            if (run && $urandom_range(0, 15) != 0) begin
                ch = (base + i) % 256;
            end else begin
                ch = (base + $urandom_range(0, span - 1)) % 256;
            end
            send_char(ch, i == len - 1);
        end
    endtask

    task automatic wait_all_results();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = draw_wait(rx_mode);
            end
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result('{m_tdata[LEN_W-1:0], m_tdata[2*LEN_W-1:LEN_W],
                              m_tlast, m_tuser[0]});
        end
    end

    initial begin : stimulus
        int random_sent;
        int string_count;
        int len;
        int span;
        bit run;
        sb          = new();
        hold_cycles = 0;
        tx_mode     = IDLE_NONE;
        rx_mode     = IDLE_NONE;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: one-byte strings at both byte extremes, then the classic cases
        tx_mode = IDLE_LIGHT;
        rx_mode = IDLE_FULL;
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        send_word("abcabcbb");
        send_word("bbbb");
        send_word("pwwkew");
        // second b must not pull the start back behind the first repeat
        send_word("abba");

        random_sent  = 0;
        string_count = 0;
        while (random_sent < 1550) begin
            tx_mode = idle_mode_t'($urandom_range(0, 2));
            rx_mode = idle_mode_t'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0: span = 2;
                1: span = 4;
                2: span = 16;
                default: span = 256;
            endcase
            run = 1'b0;
            len = $urandom_range(1, 40);
            if ($urandom_range(0, 19) == 0) begin
                len  = $urandom_range(260, 600);
                span = 256;
                run  = 1'b1;
            end
            if (string_count == 10) begin
                // receiver holds off while the sender keeps pushing
                tx_mode     = IDLE_NONE;
                len         = 80;
                hold_cycles = 300;
            end
            if (string_count == 20) begin
                wait_all_results();
            end
            send_random_string(len, span, run);
            random_sent += len;
            string_count++;
        end

        wait_all_results();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
